// ===== rtl/core/wbpd_pkg.sv =====
package wbpd_pkg;

  localparam int FRAME_COUNT_BITS = 24;
  localparam int BIN_COUNT_BITS   = 16;
  localparam int SAMPLE_BITS      = 24;
  localparam int SUM_BITS         = FRAME_COUNT_BITS + BIN_COUNT_BITS + 1;
  localparam int CFG_DATA_BITS    =
    (FRAME_COUNT_BITS > BIN_COUNT_BITS) ? FRAME_COUNT_BITS : BIN_COUNT_BITS;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [0:0] {
    CFG_CLIP_FRAMES = 1'b0,
    CFG_BIN_REQUEST = 1'b1
  } wbpd_cfg_index_t;

  typedef struct packed {
    logic                     write_enable;
    wbpd_cfg_index_t          index;
    logic [CFG_DATA_BITS-1:0] data;
  } wbpd_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } wbpd_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]    bin_peak;
    logic [BIN_COUNT_BITS-1:0] bin_number;
    logic                      final_bin;
  } wbpd_out_t;

endpackage

// ===== rtl/core/wbpd_frame_peak.sv =====
module wbpd_frame_peak (
  input  wbpd_pkg::wbpd_in_t                frame,
  output logic [wbpd_pkg::SAMPLE_BITS-1:0]  frame_peak
);
  import wbpd_pkg::*;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] u);
    logic [SAMPLE_BITS-1:0] v;
    v = u[SAMPLE_BITS-1] ? (~u + SAMPLE_BITS'(1)) : u;
    if (v > FULL_SCALE) begin
      v = FULL_SCALE;
    end
    return v;
  endfunction

  logic [SAMPLE_BITS-1:0] left_mag;
  logic [SAMPLE_BITS-1:0] right_mag;

  assign left_mag   = magnitude(frame.left_sample);
  assign right_mag  = magnitude(frame.right_sample);
  assign frame_peak = (left_mag > right_mag) ? left_mag : right_mag;

endmodule

// ===== rtl/core/wbpd_bin_tracker.sv =====
module wbpd_bin_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  wbpd_pkg::wbpd_cfg_t               cfg,
  input  logic                              step,
  input  logic [wbpd_pkg::SAMPLE_BITS-1:0]  frame_peak,
  output logic                              emit,
  output wbpd_pkg::wbpd_out_t               result
);
  import wbpd_pkg::*;

  logic [FRAME_COUNT_BITS-1:0] clip_frames;
  logic [BIN_COUNT_BITS-1:0]   bin_request;
  logic [FRAME_COUNT_BITS-1:0] frames_taken;
  logic [BIN_COUNT_BITS-1:0]   bins_emitted;
  logic [SUM_BITS-1:0]         frame_scaled_sum;
  logic [SUM_BITS-1:0]         bin_edge_sum;
  logic [SAMPLE_BITS-1:0]      running_peak;

  logic [BIN_COUNT_BITS-1:0]   bin_count;
  logic                        active;
  logic [SAMPLE_BITS-1:0]      peak_max;
  logic [SUM_BITS-1:0]         frame_scaled_sum_next;
  logic                        edge_cross;

  always_comb begin
    if (FRAME_COUNT_BITS'(bin_request) < clip_frames) begin
      bin_count = bin_request;
    end else begin
      bin_count = clip_frames[BIN_COUNT_BITS-1:0];
    end
  end

  assign active = (clip_frames != '0) && (bin_count != '0) && (frames_taken < clip_frames);
  assign peak_max = (frame_peak > running_peak) ? frame_peak : running_peak;
  assign frame_scaled_sum_next = frame_scaled_sum + SUM_BITS'(bin_count);
  assign edge_cross = (frame_scaled_sum_next + SUM_BITS'(bin_count)) >
                      (bin_edge_sum + SUM_BITS'(clip_frames));
  assign emit = step && active && edge_cross;

  assign result.bin_peak   = peak_max;
  assign result.bin_number = bins_emitted;
  assign result.final_bin  =
    ((BIN_COUNT_BITS+1)'(bins_emitted) + (BIN_COUNT_BITS+1)'(1)) ==
    (BIN_COUNT_BITS+1)'(bin_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_frames      <= '0;
      bin_request      <= '0;
      frames_taken     <= '0;
      bins_emitted     <= '0;
      frame_scaled_sum <= '0;
      bin_edge_sum     <= '0;
      running_peak     <= '0;
    end else if (cfg.write_enable) begin
      unique case (cfg.index)
        CFG_CLIP_FRAMES: clip_frames <= cfg.data[FRAME_COUNT_BITS-1:0];
        CFG_BIN_REQUEST: bin_request <= cfg.data[BIN_COUNT_BITS-1:0];
        default: ;
      endcase
      frames_taken     <= '0;
      bins_emitted     <= '0;
      frame_scaled_sum <= '0;
      bin_edge_sum     <= '0;
      running_peak     <= '0;
    end else if (step && active) begin
      frames_taken     <= frames_taken + FRAME_COUNT_BITS'(1);
      frame_scaled_sum <= frame_scaled_sum_next;
      if (edge_cross) begin
        running_peak <= '0;
        bin_edge_sum <= bin_edge_sum + SUM_BITS'(clip_frames);
        bins_emitted <= bins_emitted + BIN_COUNT_BITS'(1);
      end else begin
        running_peak <= peak_max;
      end
    end
  end

`ifndef SYNTHESIS
  // never more bins than the effective count
  a_bins_bounded: assert property (@(posedge clk) disable iff (rst)
    bins_emitted <= bin_count)
    else $error("bins emitted exceed bin count");

  // once every bin is out the clip is over
  a_no_emit_after_last: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg.write_enable && bins_emitted == bin_count) |-> !emit)
    else $error("bin emitted after the last bin");

  // the last bin closes on the last frame of the clip
  a_final_on_last_frame: assert property (@(posedge clk) disable iff (rst)
    (emit && result.final_bin && !cfg.write_enable) |=> (frames_taken == clip_frames))
    else $error("final bin not on last frame");
`endif

endmodule

// ===== rtl/core/waveform_bin_peak_decimator.sv =====
// One stereo frame is accepted per clock cycle when the result side keeps up. A frame is
// registered in the input register, and its bin result, if the frame closes a bin, is
// registered in the result register as the frame leaves the input register, raising
// peak_valid. The input stalls only while a frame is held and a waiting peak is stalled.
// The per-frame path is the absolute value and max of both samples followed by the 41-bit
// add-and-compare of the bin edge accumulators. Program clip_frames and bin_request while
// idle; each write restarts the clip. Frames past the end of the clip, or while either
// count is zero, are taken and dropped.
module waveform_bin_peak_decimator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 frame_valid,
  output logic                                 frame_stall,
  input  wbpd_pkg::wbpd_in_t                   frame,
  output logic                                 peak_valid,
  input  logic                                 peak_stall,
  output wbpd_pkg::wbpd_out_t                  peak,
  input  logic                                 cfg_write_enable,
  input  wbpd_pkg::wbpd_cfg_index_t            cfg_index,
  input  logic [wbpd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import wbpd_pkg::*;

  logic                   stage_valid;
  wbpd_in_t               stage_word;
  logic                   advance;
  logic                   frame_accept;
  logic [SAMPLE_BITS-1:0] frame_peak;
  logic                   emit;
  wbpd_out_t              result;
  wbpd_cfg_t              cfg;

  assign cfg.write_enable = cfg_write_enable;
  assign cfg.index        = cfg_index;
  assign cfg.data         = cfg_data;

  assign advance      = stage_valid && !(peak_valid && peak_stall);
  assign frame_stall  = stage_valid && peak_valid && peak_stall;
  assign frame_accept = frame_valid && !frame_stall;

  wbpd_frame_peak u_frame_peak (
    .frame      (stage_word),
    .frame_peak (frame_peak)
  );

  wbpd_bin_tracker u_bin_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (advance),
    .frame_peak (frame_peak),
    .emit       (emit),
    .result     (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (frame_accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_accept) begin
      stage_word <= frame;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (advance && emit) begin
      peak_valid <= 1'b1;
    end else if (!peak_stall) begin
      peak_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      peak <= result;
    end
  end

endmodule

// ===== test/tb_waveform_bin_peak_decimator.sv =====
`timescale 1ns / 1ps

module tb_waveform_bin_peak_decimator;
  import wbpd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic                     clk;
  logic                     rst;
  logic                     frame_valid;
  logic                     frame_stall;
  wbpd_in_t                 frame;
  logic                     peak_valid;
  logic                     peak_stall;
  wbpd_out_t                peak;
  logic                     cfg_write_enable;
  wbpd_cfg_index_t          cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  waveform_bin_peak_decimator u_dut (
    .clk              (clk),
    .rst              (rst),
    .frame_valid      (frame_valid),
    .frame_stall      (frame_stall),
    .frame            (frame),
    .peak_valid       (peak_valid),
    .peak_stall       (peak_stall),
    .peak             (peak),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // predictor state
  logic [FRAME_COUNT_BITS-1:0] clip_n;
  logic [BIN_COUNT_BITS-1:0]   bin_req;
  logic [63:0]                 frames_in;
  logic [63:0]                 bins_out;
  logic [63:0]                 frame_acc;
  logic [63:0]                 edge_acc;
  logic [SAMPLE_BITS-1:0]      open_peak;

  wbpd_out_t peak_q[$];

  int errors;
  int peaks_checked;
  int frames_used;
  int reg_writes;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;
  int hold_len;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d peaks still expected", cycle_count,
               peak_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stall plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_cnt == 0 && hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      peak_stall <= 1'b1;
    end else begin
      peak_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    wbpd_out_t want;
    if (!rst && peak_valid && !peak_stall) begin
      if (peak_q.size() == 0) begin
        report_mismatch("unexpected peak word, bin", 32'(peak.bin_number), 0);
      end else begin
        want = peak_q.pop_front();
        peaks_checked++;
        if (peak.bin_peak !== want.bin_peak)
          report_mismatch("bin_peak", 32'(peak.bin_peak), 32'(want.bin_peak));
        if (peak.bin_number !== want.bin_number)
          report_mismatch("bin_number", 32'(peak.bin_number), 32'(want.bin_number));
        if (peak.final_bin !== want.final_bin)
          report_mismatch("final_bin", 32'(peak.final_bin), 32'(want.final_bin));
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] sample_mag(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS:0] v;
    if (s[SAMPLE_BITS-1]) v = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, s};
    else v = {1'b0, s};
    if (v > FULL_SCALE) v = FULL_SCALE;
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic clear_clip();
    frames_in = 0;
    bins_out  = 0;
    frame_acc = 0;
    edge_acc  = 0;
    open_peak = '0;
  endtask

  task automatic queue_expected(input wbpd_out_t pk);
    peak_q = {peak_q, pk};
  endtask

  task automatic predict_frame(input wbpd_in_t f);
    logic [63:0]            n;
    logic [63:0]            k;
    logic [SAMPLE_BITS-1:0] pl;
    logic [SAMPLE_BITS-1:0] pr;
    logic [SAMPLE_BITS-1:0] p;
    wbpd_out_t              pk;
    n = 64'(clip_n);
    k = (bin_req < clip_n) ? 64'(bin_req) : 64'(clip_n);
    if (n == 0 || k == 0 || frames_in >= n) return;
    frames_used++;
    pl = sample_mag(f.left_sample);
    pr = sample_mag(f.right_sample);
    p  = (pl > pr) ? pl : pr;
    if (p > open_peak) open_peak = p;
    frame_acc = frame_acc + k;
    frames_in = frames_in + 64'd1;
    if (frame_acc + k > edge_acc + n) begin
      pk.bin_peak   = open_peak;
      pk.bin_number = bins_out[BIN_COUNT_BITS-1:0];
      pk.final_bin  = (bins_out + 64'd1 == k);
      queue_expected(pk);
      edge_acc  = edge_acc + n;
      bins_out  = bins_out + 64'd1;
      open_peak = '0;
    end
  endtask

  task automatic wait_for_peaks();
    if (peak_q.size() != 0) begin
      frame_valid <= 1'b0;
      while (peak_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(input wbpd_cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
    wait_for_peaks();
    frame_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    reg_writes++;
    if (idx == CFG_CLIP_FRAMES) clip_n = val[FRAME_COUNT_BITS-1:0];
    else bin_req = val[BIN_COUNT_BITS-1:0];
    clear_clip();
  endtask

  task automatic set_clip(input logic [CFG_DATA_BITS-1:0] n,
                          input logic [CFG_DATA_BITS-1:0] k);
    write_reg(CFG_CLIP_FRAMES, n);
    write_reg(CFG_BIN_REQUEST, k);
  endtask

  task automatic send_frame(input wbpd_in_t f);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= f;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    predict_frame(f);
  endtask

  task automatic send_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
    wbpd_in_t f;
    f.left_sample  = l;
    f.right_sample = r;
    send_frame(f);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(15))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      4: return 24'h800001;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    send_pair(pick_sample(), pick_sample());
  endtask

  // counts are zero straight out of reset
  task automatic test_reset_defaults();
    send_pair(24'h123456, 24'h800000);
    send_pair(24'h7FFFFF, 24'h000001);
  endtask

  task automatic test_zero_counts();
    set_clip(5, 0);
    send_pair(24'h400000, 24'hC00000);
    send_pair(24'h000010, 24'hFFFFF0);
    set_clip(0, 4);
    send_pair(24'h7FFFFF, 24'h800000);
  endtask

  // one frame per bin, full scale magnitudes, frames past the clip dropped
  task automatic test_full_scale_extremes();
    set_clip(4, 24'h00FFFF);
    send_pair(24'h800000, 24'h000000);
    send_pair(24'h7FFFFF, 24'h800001);
    send_pair(24'h000000, 24'h000000);
    send_pair(24'hFFFFFF, 24'h000001);
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 24'h800000);
  endtask

  // upper data bits of the bin request are masked off
  task automatic test_uneven_bins_masked_write();
    set_clip(7, 24'hFF0003);
    send_pair(24'h000100, 24'hFFFE00);
    send_pair(24'h100000, 24'h000000);
    send_pair(24'h000005, 24'h000003);
    send_pair(24'hF00000, 24'h0FFFFF);
    send_pair(24'h000001, 24'h000000);
    send_pair(24'h000000, 24'h800000);
    send_pair(24'h7FFFFE, 24'h000002);
    send_pair(24'h7FFFFF, 24'h7FFFFF);
  endtask

  task automatic test_restart_mid_clip();
    set_clip(6, 2);
    send_pair(24'h7FFFFF, 24'h000000);
    send_pair(24'h000000, 24'h800000);
    write_reg(CFG_CLIP_FRAMES, 3);
    send_pair(24'h000040, 24'h000020);
    send_pair(24'hFFFFC0, 24'h000000);
    send_pair(24'h000000, 24'h000001);
  endtask

  task automatic test_backpressure_fill();
    int i;
    set_clip(200, 100);
    hold_len = 300;
    for (i = 0; i < 200; i++) begin
      if (i == 100) wait_for_peaks();
      send_random_frame();
    end
    wait_for_peaks();
  endtask

  task automatic test_largest_clip();
    int i;
    set_clip(24'hFFFFFF, 24'hFFFFFF);
    for (i = 0; i < 520; i++) send_random_frame();
    wait_for_peaks();
  endtask

  task automatic run_random_clips(input int idle_pct, input int stall_in_pct, input int quota);
    int                       start;
    int                       len;
    int                       i;
    int                       r;
    logic [CFG_DATA_BITS-1:0] n;
    logic [CFG_DATA_BITS-1:0] k;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    start         = frames_used;
    while (frames_used - start < quota) begin
      r = $urandom_range(99);
      if (r < 5) n = 0;
      else if (r < 85) n = CFG_DATA_BITS'($urandom_range(48, 1));
      else n = CFG_DATA_BITS'($urandom_range(300, 49));
      r = $urandom_range(99);
      if (r < 5) k = 0;
      else if (r < 15) k = 24'h00FFFF;
      else if (r < 25) k = CFG_DATA_BITS'(32'(n) + 1 + $urandom_range(100) +
                                          ($urandom_range(1) << 20));
      else k = (n == 0) ? CFG_DATA_BITS'(1) : CFG_DATA_BITS'($urandom_range(32'(n), 1));
      if ($urandom_range(1)) begin
        set_clip(n, k);
      end else begin
        write_reg(CFG_BIN_REQUEST, k);
        write_reg(CFG_CLIP_FRAMES, n);
      end
      if (n == 0 || k[BIN_COUNT_BITS-1:0] == 0) len = 3;
      else if ($urandom_range(9) == 0) len = $urandom_range(32'(n) - 1);
      else len = 32'(n) + (($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(99) < 2) wait_for_peaks();
        send_random_frame();
      end
    end
    wait_for_peaks();
  endtask

  initial begin
    int waited;
    clip_n  = '0;
    bin_req = '0;
    clear_clip();
    errors        = 0;
    peaks_checked = 0;
    frames_used   = 0;
    reg_writes    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 0;
    hold_cnt      = 0;
    rst              <= 1'b1;
    frame_valid      <= 1'b0;
    frame            <= '0;
    peak_stall       <= 1'b0;
    cfg_write_enable <= 1'b0;
    cfg_index        <= CFG_CLIP_FRAMES;
    cfg_data         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_zero_counts();
    test_full_scale_extremes();
    test_uneven_bins_masked_write();
    test_restart_mid_clip();
    test_backpressure_fill();
    test_largest_clip();
    run_random_clips(0, 0, 250);
    run_random_clips(75, 0, 250);
    run_random_clips(0, 75, 250);
    run_random_clips(35, 35, 250);

    frame_valid <= 1'b0;
    waited = 0;
    while (peak_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (peak_q.size() != 0) report_mismatch("peaks never delivered", peak_q.size(), 0);

    $display("covered %0d clip frames and %0d bin peaks over %0d register writes,",
             frames_used, peaks_checked, reg_writes);
    $display("with zero counts, restarts, full scale samples and four idle/stall mixes");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wbpd_pkg.sv
rtl/core/wbpd_frame_peak.sv
rtl/core/wbpd_bin_tracker.sv
rtl/core/waveform_bin_peak_decimator.sv
test/tb_waveform_bin_peak_decimator.sv
